[rtl/core/sat_pkg.sv]
`timescale 1ns / 1ps

package sat_pkg;

   localparam int AddrFieldWidth = 32;
   localparam int IndexWidth     = 4;
   localparam int CountWidth     = 5;
   localparam int MaxTableDepth  = 16;

   localparam logic [AddrFieldWidth-1:0] NoAddress = '1;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_FORWARD = 2'd1,
      OP_REVERSE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      logic [AddrFieldWidth-1:0] virtual_base;
      logic [AddrFieldWidth-1:0] raw_size;
      logic [AddrFieldWidth-1:0] raw_pointer;
   } entry_type;

   typedef struct packed {
      logic write;
      logic start;
      logic step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

[rtl/core/sat_ctrl.sv]
`timescale 1ns / 1ps

module sat_ctrl import sat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  op_type     req_op,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      is_lookup;
   logic      out_free;

   always_comb begin
      case (req_op) inside
         OP_FORWARD, OP_REVERSE: is_lookup = 1'b1;
         default:                is_lookup = 1'b0;
      endcase
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign cmd.write    = accept && (req_op == OP_WRITE);
   assign cmd.start    = accept && is_lookup;
   assign cmd.step     = (state_ff == ST_SCAN);
   assign cmd.load_rsp = (state_ff == ST_DELIVER) && out_free;
   assign rsp_tvalid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/sat_dp.sv]
`timescale 1ns / 1ps

module sat_dp import sat_pkg::*; #(
   parameter int TableDepth = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_we,
   input  logic [CountWidth-1:0]     csr_wdata,
   input  op_type                    req_op,
   input  logic [IndexWidth-1:0]     req_entry_index,
   input  logic [AddrFieldWidth-1:0] req_virtual_base,
   input  logic [AddrFieldWidth-1:0] req_raw_size,
   input  logic [AddrFieldWidth-1:0] req_raw_pointer,
   input  logic [AddrFieldWidth-1:0] req_lookup_address,
   output logic                      rsp_found,
   output logic [IndexWidth-1:0]     rsp_section_number,
   output logic [AddrFieldWidth-1:0] rsp_offset_in_section,
   output logic [AddrFieldWidth-1:0] rsp_translated_address
);

   localparam int AddrWidth = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(TableDepth);

   entry_type                 table_ff [TableDepth];
   logic [CountWidth-1:0]     count_ff;
   logic [CountWidth-1:0]     active_count;

   logic                      forward_ff;
   logic [AddrFieldWidth-1:0] addr_ff;
   logic [CountWidth-1:0]     rd_idx_ff;
   logic [CountWidth-1:0]     rd_idx_in;
   logic                      rd_valid_ff;
   logic                      rd_valid_in;
   logic [IndexWidth-1:0]     rd_tag_ff;
   entry_type                 rd_data_ff;
   logic                      rd_more;

   logic                      hit_ff;
   logic [IndexWidth-1:0]     which_ff;
   logic [AddrFieldWidth-1:0] hit_base_ff;
   logic [AddrFieldWidth-1:0] hit_other_ff;

   logic [AddrFieldWidth-1:0] scan_base;
   logic [AddrFieldWidth-1:0] scan_other;
   logic [AddrFieldWidth-1:0] scan_end;
   logic                      match;
   logic [AddrFieldWidth-1:0] hit_offset;

   assign active_count = (count_ff < DepthCount) ? count_ff : DepthCount;
   assign rd_more      = (rd_idx_ff < active_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && ({1'b0, req_entry_index} < DepthCount)) begin
         table_ff[req_entry_index[AddrWidth-1:0]] <= '{
            virtual_base: req_virtual_base,
            raw_size:     req_raw_size,
            raw_pointer:  req_raw_pointer
         };
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && rd_more) begin
         rd_data_ff <= table_ff[rd_idx_ff[AddrWidth-1:0]];
         rd_tag_ff  <= rd_idx_ff[IndexWidth-1:0];
      end
   end

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.start) begin
         rd_idx_in   = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.step) begin
         rd_valid_in = rd_more;
         if (rd_more) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   assign scan_base  = forward_ff ? rd_data_ff.virtual_base : rd_data_ff.raw_pointer;
   assign scan_other = forward_ff ? rd_data_ff.raw_pointer : rd_data_ff.virtual_base;
   assign scan_end   = scan_base + rd_data_ff.raw_size;
   assign match      = rd_valid_ff && (addr_ff >= scan_base) && (addr_ff < scan_end);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         forward_ff <= (req_op == OP_FORWARD);
         addr_ff    <= req_lookup_address;
         hit_ff     <= 1'b0;
      end else if (cmd.step && match) begin
         hit_ff       <= 1'b1;
         which_ff     <= rd_tag_ff;
         hit_base_ff  <= scan_base;
         hit_other_ff <= scan_other;
      end
   end

   assign hit_offset = addr_ff - hit_base_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found <= hit_ff;
         if (hit_ff) begin
            rsp_section_number     <= which_ff;
            rsp_offset_in_section  <= hit_offset;
            rsp_translated_address <= hit_offset + hit_other_ff;
         end else begin
            rsp_section_number     <= '0;
            rsp_offset_in_section  <= '0;
            rsp_translated_address <= NoAddress;
         end
      end
   end

   assign status.scan_done = !rd_more && !rd_valid_ff;

endmodule

[rtl/core/section_address_translator.sv]
`timescale 1ns / 1ps

// Section table with forward (virtual to file) and reverse (file to virtual)
// lookups. A write request loads one entry and gives no response. A lookup
// request scans the active entries one per cycle out of a single-read table
// with registered read data, keeps the last entry that covers the address,
// and then loads the response register once the output register is free.
// The next request is taken the cycle after the response load. The block
// holds one lookup at a time; a response waiting in the output register
// does not block the next request. A miss returns found low, zero number
// and offset, and an all-ones translated address. section_count above the
// table depth (the smaller of MAX_SECTIONS and 16) acts as the table depth.
module section_address_translator import sat_pkg::*; #(
   parameter int MAX_SECTIONS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] entry_index, [35:4] virtual_base, [67:36] raw_size,
   // [99:68] raw_pointer, [131:100] lookup_address, [135:132] zero
   input  logic [135:0] req_tdata,
   // [1:0] operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] section_number, [35:4] offset_in_section,
   // [67:36] translated_address, [71:68] zero
   output logic [71:0]  rsp_tdata,
   // [0] found
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);

   localparam int TableDepth = (MAX_SECTIONS < MaxTableDepth) ? MAX_SECTIONS : MaxTableDepth;

   cmd_type                   cmd;
   status_type                status;
   op_type                    req_op;
   logic [IndexWidth-1:0]     section_number;
   logic [AddrFieldWidth-1:0] offset_in_section;
   logic [AddrFieldWidth-1:0] translated_address;

   assign req_op = op_type'(req_tuser);

   sat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sat_dp #(
      .TableDepth (TableDepth)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .req_op                 (req_op),
      .req_entry_index        (req_tdata[3:0]),
      .req_virtual_base       (req_tdata[35:4]),
      .req_raw_size           (req_tdata[67:36]),
      .req_raw_pointer        (req_tdata[99:68]),
      .req_lookup_address     (req_tdata[131:100]),
      .rsp_found              (rsp_tuser),
      .rsp_section_number     (section_number),
      .rsp_offset_in_section  (offset_in_section),
      .rsp_translated_address (translated_address)
   );

   assign rsp_tdata = {4'b0000, translated_address, offset_in_section, section_number};

   // A miss always carries zero number and offset and an all-ones translated address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[35:0] == '0 && rsp_tdata[67:36] == NoAddress)
      else $error("miss response carries nonzero payload");

   // Hold off requests for the cycle after a lookup is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_op == OP_FORWARD || req_op == OP_REVERSE)
      |=> !req_tready)
      else $error("request taken while a lookup is in flight");

   // Scanning never overlaps accepting a request or loading a response.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_tready && !cmd.load_rsp)
      else $error("scan overlaps accept or response load");

   // A response only appears after a load from the datapath.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_rsp))
      else $error("response raised without a load");

endmodule
